// ----- rtl/core/calendar_clock_advance_assert.svh -----
// Assertion macros for the calendar clock block.
`ifndef CALENDAR_CLOCK_ADVANCE_ASSERT_SVH
`define CALENDAR_CLOCK_ADVANCE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk_i, quiet during reset.
`define CCA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar clock: implication check failed");
// Next-cycle implication.
`define CCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar clock: next-cycle check failed");
`else
`define CCA_ASSERT_IMPLY(label, ante, cons)
`define CCA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/cca_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cca_pkg;

  typedef enum logic {
    ReqAdvance = 1'b0,
    ReqSet     = 1'b1
  } req_kind_e;

  // Radices of the carry chain
  localparam logic [6:0]  SecPerMin   = 7'd60;
  localparam logic [6:0]  MinPerHour  = 7'd60;
  localparam logic [6:0]  HourPerDay  = 7'd24;
  localparam logic [6:0]  HourTwoDays = 7'(2 * 24);
  localparam logic [15:0] YearMax     = 16'hFFFF;

  // floor(x / 60) by reciprocal: exact for x < 381300 with shift 24,
  // and for x < 4681 with shift 17
  localparam logic [18:0] Recip60Wide   = 19'd279621;
  localparam int unsigned Recip60WideSh = 24;
  localparam logic [11:0] Recip60Narrow = 12'd2185;
  localparam int unsigned Recip60NarSh  = 17;

  // y divisible by 25 <=> (y * inverse of 25 mod 2^16) <= floor(65535 / 25)
  localparam logic [15:0] Inv25      = 16'd23593;
  localparam logic [15:0] Div25Limit = 16'(65535 / 25);

  localparam logic [3:0] MonJan = 4'd1;
  localparam logic [3:0] MonFeb = 4'd2;
  localparam logic [3:0] MonApr = 4'd4;
  localparam logic [3:0] MonJun = 4'd6;
  localparam logic [3:0] MonSep = 4'd9;
  localparam logic [3:0] MonNov = 4'd11;
  localparam logic [3:0] MonDec = 4'd12;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } clock_state_t;

  // Request after the delta has been split into mixed radix
  typedef struct packed {
    req_kind_e   kind;
    logic [5:0]  sec_add;
    logic [5:0]  min_add;
    logic [5:0]  hour_add;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [15:0] set_year;
    logic        set_ok;
    logic        set_leap;
  } prep_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      MonFeb: len = leap ? 5'd29 : 5'd28;
      MonApr, MonJun, MonSep, MonNov: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // 4/100/400 rule: divisible by 4, and not by 25 unless also by 16
  function automatic logic is_leap(input logic [15:0] year);
    logic [15:0] prod;
    logic        div25;
    prod  = year * Inv25;
    div25 = (prod <= Div25Limit);
    return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'h0));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/calendar_clock_advance.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake          Payload
// request   in         valid_i / stall_o  req_type_i, delta_seconds_i, set_*_i
// result    out        valid_o / stall_i  cur_*_o, date_ok_o
//
// One request per cycle sustained while the result side does not stall.
// Two reciprocal multiplications split the delta into seconds, minutes
// and hours, each followed by a register.
// Reset clears the clock to 0000-00-00 00:00:00 and empties the pipeline.
// A stalled result holds; empty stages upstream still take requests.

`include "calendar_clock_advance_assert.svh"

module calendar_clock_advance (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [0:0]  req_type_i,
  input  logic [16:0] delta_seconds_i,
  input  logic [4:0]  set_day_i,
  input  logic [3:0]  set_month_i,
  input  logic [15:0] set_year_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [5:0]  cur_second_o,
  output logic [5:0]  cur_minute_o,
  output logic [4:0]  cur_hour_o,
  output logic [4:0]  cur_day_o,
  output logic [3:0]  cur_month_o,
  output logic [15:0] cur_year_o,
  output logic        date_ok_o
);
  import cca_pkg::*;

  // Pipeline occupancy: input register, first split, second split, result
  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;

  // Stage 0: raw request
  req_kind_e   s0_kind_q;
  logic [16:0] s0_delta_q;
  logic [4:0]  s0_day_q;
  logic [3:0]  s0_month_q;
  logic [15:0] s0_year_q;

  // Stage 1: delta split into seconds and whole minutes, set date checked
  req_kind_e   s1_kind_q;
  logic [5:0]  s1_sec_q;
  logic [11:0] s1_quot_q;
  logic [4:0]  s1_day_q;
  logic [3:0]  s1_month_q;
  logic [15:0] s1_year_q;
  logic        s1_ok_q, s1_leap_q;

  // Stage 2: fully split request
  prep_t s2_q;

  // Clock state, which is also the result register
  clock_state_t state_q, state_d;
  logic         leap_q, leap_d;
  logic         ok_q, ok_d;
  logic         next_leap;

  logic [35:0] prod1;
  logic [11:0] quot1;
  logic [17:0] quot1_x60, rem1;
  logic        set_leap, set_ok;
  logic [23:0] prod2;
  logic [5:0]  hours2;
  logic [11:0] hours2_x60, rem2;
  prep_t       s2_d;

  // Each stage moves when the one below is empty or moving on
  assign rdy3    = !v3_q || !stall_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign rdy0    = !v0_q || rdy1;
  assign stall_o = !rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && valid_i) begin
      s0_kind_q  <= req_kind_e'(req_type_i);
      s0_delta_q <= delta_seconds_i;
      s0_day_q   <= set_day_i;
      s0_month_q <= set_month_i;
      s0_year_q  <= set_year_i;
    end
  end

  // Stage 0 -> 1: delta / 60 by reciprocal, remainder by shift-subtract
  always_comb begin
    prod1     = 36'(s0_delta_q) * 36'(Recip60Wide);
    quot1     = 12'(prod1 >> Recip60WideSh);
    quot1_x60 = {quot1, 6'b0} - {4'b0, quot1, 2'b0};
    rem1      = {1'b0, s0_delta_q} - quot1_x60;
    set_leap  = is_leap(s0_year_q);
    set_ok    = (s0_month_q >= MonJan) && (s0_month_q <= MonDec) &&
                (s0_day_q != 5'd0) && (s0_day_q <= month_len(s0_month_q, set_leap));
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) begin
      s1_kind_q  <= s0_kind_q;
      s1_sec_q   <= rem1[5:0];
      s1_quot_q  <= quot1;
      s1_day_q   <= s0_day_q;
      s1_month_q <= s0_month_q;
      s1_year_q  <= s0_year_q;
      s1_ok_q    <= set_ok;
      s1_leap_q  <= set_leap;
    end
  end

  // Stage 1 -> 2: minutes / 60 into hours and minutes
  always_comb begin
    prod2      = 24'(s1_quot_q) * 24'(Recip60Narrow);
    hours2     = 6'(prod2 >> Recip60NarSh);
    hours2_x60 = {hours2, 6'b0} - {4'b0, hours2, 2'b0};
    rem2       = s1_quot_q - hours2_x60;

    s2_d.kind      = s1_kind_q;
    s2_d.sec_add   = s1_sec_q;
    s2_d.min_add   = rem2[5:0];
    s2_d.hour_add  = hours2;
    s2_d.set_day   = s1_day_q;
    s2_d.set_month = s1_month_q;
    s2_d.set_year  = s1_year_q;
    s2_d.set_ok    = s1_ok_q;
    s2_d.set_leap  = s1_leap_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
  end

  // Leap flag of the following year, ready in case December rolls over
  assign next_leap = is_leap(state_q.year + 16'd1);

  cca_step u_step (
    .state_i     (state_q),
    .leap_i      (leap_q),
    .next_leap_i (next_leap),
    .item_i      (s2_q),
    .state_o     (state_d),
    .leap_o      (leap_d),
    .ok_o        (ok_d)
  );

  // The state is updated only when its result enters the output slot,
  // so the output slot and the state always agree.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      leap_q  <= 1'b1;
      ok_q    <= 1'b0;
    end else if (rdy3 && v2_q) begin
      state_q <= state_d;
      leap_q  <= leap_d;
      ok_q    <= ok_d;
    end
  end

  assign valid_o      = v3_q;
  assign cur_second_o = state_q.second;
  assign cur_minute_o = state_q.minute;
  assign cur_hour_o   = state_q.hour;
  assign cur_day_o    = state_q.day;
  assign cur_month_o  = state_q.month;
  assign cur_year_o   = state_q.year;
  assign date_ok_o    = ok_q;

  // Cached leap flag must follow the year
  `CCA_ASSERT_IMPLY(a_leap_tracks_year, 1'b1, leap_q == is_leap(state_q.year))
  // Results stay within the calendar
  `CCA_ASSERT_IMPLY(a_result_range, valid_o,
                    (cur_second_o < 6'd60) && (cur_minute_o < 6'd60) &&
                    (cur_hour_o < 5'd24) && (cur_month_o <= MonDec))
  // A rejected set leaves an all-zero clock
  `CCA_ASSERT_IMPLY(a_reject_clears, valid_o && !date_ok_o,
                    (cur_month_o == 4'd0) && (cur_year_o == 16'd0) && (cur_day_o == 5'd0))
  // State moves only when a request lands in the result slot
  `CCA_ASSERT_NEXT(a_state_hold, !(rdy3 && v2_q), $stable(state_q))

endmodule

`default_nettype wire

// ----- rtl/core/cca_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cca_step (
  input  cca_pkg::clock_state_t state_i,
  input  logic                  leap_i,
  input  logic                  next_leap_i,
  input  cca_pkg::prep_t        item_i,
  output cca_pkg::clock_state_t state_o,
  output logic                  leap_o,
  output logic                  ok_o
);
  import cca_pkg::*;

  logic [6:0]  sec_sum, min_sum, hour_sum;
  logic        sec_cy, min_cy;
  logic [1:0]  day_cy;
  logic [5:0]  day_sum, len;
  logic        roll, year_cy, year_inc;
  clock_state_t adv;

  always_comb begin
    adv = state_i;

    sec_sum = 7'(state_i.second) + 7'(item_i.sec_add);
    sec_cy  = (sec_sum >= SecPerMin);
    adv.second = sec_cy ? 6'(sec_sum - SecPerMin) : sec_sum[5:0];

    min_sum = 7'(state_i.minute) + 7'(item_i.min_add) + 7'(sec_cy);
    min_cy  = (min_sum >= MinPerHour);
    adv.minute = min_cy ? 6'(min_sum - MinPerHour) : min_sum[5:0];

    // up to two days of carry for an oversized delta
    hour_sum = 7'(state_i.hour) + 7'(item_i.hour_add) + 7'(min_cy);
    if (hour_sum >= HourTwoDays) begin
      adv.hour = 5'(hour_sum - HourTwoDays);
      day_cy   = 2'd2;
    end else if (hour_sum >= HourPerDay) begin
      adv.hour = 5'(hour_sum - HourPerDay);
      day_cy   = 2'd1;
    end else begin
      adv.hour = hour_sum[4:0];
      day_cy   = 2'd0;
    end

    // day never exceeds 33 here, so one month step is enough
    day_sum  = 6'(state_i.day) + 6'(day_cy);
    len      = 6'(month_len(state_i.month, leap_i));
    roll     = (day_sum > len);
    year_cy  = roll && (state_i.month == MonDec);
    year_inc = year_cy && (state_i.year != YearMax);
    if (roll) begin
      adv.day   = 5'(day_sum - len);
      adv.month = year_cy ? MonJan : state_i.month + 4'd1;
    end else begin
      adv.day = day_sum[4:0];
    end
    if (year_inc) begin
      adv.year = state_i.year + 16'd1;
    end

    if (item_i.kind == ReqSet) begin
      state_o = '0;
      if (item_i.set_ok) begin
        state_o.year  = item_i.set_year;
        state_o.month = item_i.set_month;
        state_o.day   = item_i.set_day;
        leap_o        = item_i.set_leap;
      end else begin
        leap_o = 1'b1;  // year zero is a leap year
      end
      ok_o = item_i.set_ok;
    end else begin
      state_o = adv;
      leap_o  = year_inc ? next_leap_i : leap_i;
      ok_o    = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- tb/calendar_clock_advance_tb.sv -----
`timescale 1ns / 1ps

module calendar_clock_advance_tb;
  import cca_pkg::*;

  localparam int unsigned ClockHalf   = 5;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned TotalReqs   = 23 + 1500;   // directed part plus random part
  localparam int unsigned HoldOff     = 150;         // long receiver hold-off, in cycles
  localparam int unsigned DrainCycles = 12;          // extra wait once every result has been checked
  localparam int unsigned CycleLimit  = 300000;

  // One expected result: the clock after the request, plus the date flag.
  // Packed order matches the result ports, year first.
  typedef struct packed {
    clock_state_t snap;
    logic         ok;
  } reading_t;

  typedef enum int unsigned {RxFree, RxRandom, RxPattern, RxHeavy} rx_mode_e;

  // Tracks the calendar independently of the block and queues what each
  // accepted request should produce.
  class calendar_tracker;
    clock_state_t now = '0;
    reading_t     due[$];
    int unsigned  faults = 0;

    // Gregorian rule: every 4th year, except centuries not divisible by 400
    static function bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Any month outside 1..12 (only month zero can occur) counts as 31 days
    static function int unsigned days_in_month(int unsigned m, int unsigned y);
      case (m)
        MonFeb: return leap_year(y) ? 29 : 28;
        MonApr, MonJun, MonSep, MonNov: return 30;
        default: return 31;
      endcase
    endfunction

    function void advance_clock(int unsigned delta);
      int unsigned t, carry, day, len;
      t = now.second + delta;
      now.second = 6'(t % SecPerMin);
      carry = t / SecPerMin;
      t = now.minute + carry;
      now.minute = 6'(t % MinPerHour);
      carry = t / MinPerHour;
      t = now.hour + carry;
      now.hour = 5'(t % HourPerDay);
      carry = t / HourPerDay;
      // up to two days of carry; the month steps on while the day runs past its end
      day = now.day + carry;
      repeat (4) begin
        len = days_in_month(now.month, now.year);
        if (day > len) begin
          day -= len;
          if (now.month == MonDec) begin
            now.month = MonJan;
            if (now.year != YearMax) now.year++;
          end else begin
            now.month++;
          end
        end
      end
      now.day = 5'(day);
    endfunction

    // A bad date wipes the whole clock, a good one loads at midnight
    function bit load_date(int unsigned d, int unsigned m, int unsigned y);
      now = '0;
      if (m < MonJan || m > MonDec || d < 1 || d > days_in_month(m, y)) return 1'b0;
      now.day   = 5'(d);
      now.month = 4'(m);
      now.year  = 16'(y);
      return 1'b1;
    endfunction

    function void note_request(req_kind_e kind, logic [16:0] delta, logic [4:0] d,
                               logic [3:0] m, logic [15:0] y);
      reading_t r;
      r.ok = 1'b1;
      if (kind == ReqAdvance) advance_clock(delta);
      else r.ok = load_date(d, m, y);
      r.snap = now;
      due.push_back(r);
    endfunction

    function void compare_field(string tag, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, tag, want, seen);
        faults++;
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (due.size() == 0) begin
        $display("%0t: result with no request outstanding, got %0d-%0d-%0d", $time,
                 got.snap.year, got.snap.month, got.snap.day);
        faults++;
        return;
      end
      want = due.pop_front();
      compare_field("cur_second", want.snap.second, got.snap.second);
      compare_field("cur_minute", want.snap.minute, got.snap.minute);
      compare_field("cur_hour", want.snap.hour, got.snap.hour);
      compare_field("cur_day", want.snap.day, got.snap.day);
      compare_field("cur_month", want.snap.month, got.snap.month);
      compare_field("cur_year", want.snap.year, got.snap.year);
      compare_field("date_ok", want.ok, got.ok);
    endfunction
  endclass

  // Block ports, the inputs all known from time zero
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        valid_i         = 1'b0;
  logic        stall_o;
  logic [0:0]  req_type_i      = ReqAdvance;
  logic [16:0] delta_seconds_i = '0;
  logic [4:0]  set_day_i       = '0;
  logic [3:0]  set_month_i     = '0;
  logic [15:0] set_year_i      = '0;
  logic        valid_o;
  logic        stall_i         = 1'b0;
  logic [5:0]  cur_second_o;
  logic [5:0]  cur_minute_o;
  logic [4:0]  cur_hour_o;
  logic [4:0]  cur_day_o;
  logic [3:0]  cur_month_o;
  logic [15:0] cur_year_o;
  logic        date_ok_o;

  calendar_tracker tracker = new;
  reading_t        seen_reading;

  int unsigned sent        = 0;   // requests accepted so far
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;

  // receiver stall pattern
  rx_mode_e    rx_mode         = RxFree;
  int unsigned phase_left      = 0;
  int unsigned hold_left       = 0;
  int unsigned rx_period       = 2;
  int unsigned rx_duty         = 0;
  int unsigned tick            = 0;
  bit          early_hold_done = 1'b0;
  bit          late_hold_done  = 1'b0;

  // century and leap boundaries, plus both ends of the year range
  int unsigned notable_years [12] = '{0, 1, 4, 100, 400, 1900, 2000, 2100, 2400,
                                      65532, 65534, 65535};

  calendar_clock_advance DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .req_type_i     (req_type_i),
    .delta_seconds_i(delta_seconds_i),
    .set_day_i      (set_day_i),
    .set_month_i    (set_month_i),
    .set_year_i     (set_year_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .cur_second_o   (cur_second_o),
    .cur_minute_o   (cur_minute_o),
    .cur_hour_o     (cur_hour_o),
    .cur_day_o      (cur_day_o),
    .cur_month_o    (cur_month_o),
    .cur_year_o     (cur_year_o),
    .date_ok_o      (date_ok_o)
  );

  always begin
    #ClockHalf clk_i = 1'b1;
    #ClockHalf clk_i = 1'b0;
  end

  assign seen_reading = {cur_year_o, cur_month_o, cur_day_o, cur_hour_o,
                         cur_minute_o, cur_second_o, date_ok_o};

  // Result side: every accepted result goes straight to the tracker.
  // Sampling at the edge sees pre-edge values, as all drives are nonblocking.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) tracker.check_reading(seen_reading);
  end

  // Receiver stall: phases of free flow, random stalls, a regular pattern
  // and heavy stalling. Twice in the run it holds off for a long stretch so
  // the pipeline fills and the block has to stall the request side.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      stall_i <= 1'b1;
    end else if ((!early_hold_done && sent >= 300) || (!late_hold_done && sent >= 1000)) begin
      if (early_hold_done) late_hold_done = 1'b1;
      else early_hold_done = 1'b1;
      hold_left = HoldOff - 1;
      stall_i <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        rx_mode    = rx_mode_e'($urandom_range(0, 3));
        phase_left = $urandom_range(10, 150);
        rx_period  = $urandom_range(2, 9);
        rx_duty    = $urandom_range(10, 60);
      end
      phase_left--;
      tick++;
      case (rx_mode)
        RxFree:    stall_i <= 1'b0;
        RxRandom:  stall_i <= ($urandom_range(0, 99) < rx_duty);
        RxPattern: stall_i <= ((tick % rx_period) < (rx_period / 2));
        default:   stall_i <= ($urandom_range(0, 99) < 85);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one request and waits for it to be taken. The sender works in
  // bursts; between bursts valid drops for a random pause. Called at an edge.
  task automatic issue(req_kind_e kind, int unsigned delta, int unsigned d,
                       int unsigned m, int unsigned y);
    if (burst_left == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    valid_i         <= 1'b1;
    req_type_i      <= kind;
    delta_seconds_i <= 17'(delta);
    set_day_i       <= 5'(d);
    set_month_i     <= 4'(m);
    set_year_i      <= 16'(y);
    do @(posedge clk_i); while (stall_o);
    tracker.note_request(kind, 17'(delta), 5'(d), 4'(m), 16'(y));
    sent++;
  endtask

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 65535);
      1: return notable_years[$urandom_range(0, 11)];
      2: return $urandom_range(0, 163) * 400 + $urandom_range(0, 3) * 100;
      3: return $urandom_range(65500, 65535);
      default: return $urandom_range(1900, 2100);
    endcase
  endfunction

  // Half the time the last two days of the month, to provoke roll-overs
  function automatic int unsigned pick_day(int unsigned m, int unsigned y);
    int unsigned len;
    len = calendar_tracker::days_in_month(m, y);
    if ($urandom_range(0, 1) == 0) return $urandom_range(len - 1, len);
    return $urandom_range(1, len);
  endfunction

  function automatic int unsigned pick_delta();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 120);
      1: return $urandom_range(86340, 86399);
      2: return $urandom_range(86400, 131071);   // oversized, beyond one day
      default: return $urandom_range(0, 86399);
    endcase
  endfunction

  initial begin
    int unsigned yr, mo, dy, pick;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: from the reset state (month zero) upwards
    issue(ReqAdvance, 0, 0, 0, 0);
    issue(ReqAdvance, 86399, 31, 15, 16'hFFFF);
    issue(ReqAdvance, 1, 0, 0, 0);               // day 0 carries to day 1
    issue(ReqAdvance, 17'h1FFFF, 0, 0, 0);       // largest delta
    // leap rule at 400, 100 and 4, then bad days and months
    issue(ReqSet, 0, 29, 2, 2000);
    issue(ReqSet, 0, 29, 2, 1900);
    issue(ReqSet, 0, 29, 2, 2024);
    issue(ReqSet, 0, 29, 2, 2023);
    issue(ReqSet, 0, 0, 5, 2024);                // no day zero
    issue(ReqSet, 0, 1, 0, 2024);
    issue(ReqSet, 0, 1, 13, 2024);
    issue(ReqSet, 17'h1FFFF, 31, 15, 16'hFFFF);
    issue(ReqSet, 0, 31, 4, 2024);
    issue(ReqSet, 0, 30, 4, 2024);
    // year saturation: month wraps, year stays at its maximum
    issue(ReqSet, 0, 31, 12, 16'hFFFF);
    issue(ReqAdvance, 86399, 0, 0, 0);
    issue(ReqAdvance, 1, 0, 0, 0);
    // ordinary new year, non-leap century February, leap year zero
    issue(ReqSet, 0, 31, 12, 2024);
    issue(ReqAdvance, 17'h1FFFF, 0, 0, 0);
    issue(ReqSet, 0, 28, 2, 2100);
    issue(ReqAdvance, 17'h1FFFF, 0, 0, 0);
    issue(ReqSet, 0, 28, 2, 0);
    issue(ReqAdvance, 17'h1FFFF, 0, 0, 0);

    // Random: mostly a good date followed by a run of advances; the rest
    // is noise, near-miss dates and the odd long run from month zero.
    while (sent < TotalReqs) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        yr = pick_year();
        mo = $urandom_range(1, 12);
        dy = pick_day(mo, yr);
        issue(ReqSet, $urandom, dy, mo, yr);
        repeat ($urandom_range(1, 12))
          issue(ReqAdvance, pick_delta(), $urandom, $urandom, $urandom);
      end else if (pick < 97) begin
        case ($urandom_range(0, 2))
          0: issue(ReqSet, $urandom, $urandom, $urandom, $urandom);
          1: issue(ReqAdvance, $urandom, $urandom, $urandom, $urandom);
          default: begin
            // a day just past the month's end, or day zero
            yr = pick_year();
            mo = $urandom_range(1, 12);
            dy = calendar_tracker::days_in_month(mo, yr) + 1;
            if (dy > 31 || $urandom_range(0, 3) == 0) dy = 0;
            issue(ReqSet, $urandom, dy, mo, yr);
          end
        endcase
      end else begin
        // cleared clock, then a run of oversized advances that may pass day 31 of month zero
        issue(ReqSet, $urandom, $urandom,
              ($urandom_range(0, 1) == 0) ? 0 : 13 + $urandom_range(0, 2), $urandom);
        repeat ($urandom_range(20, 26))
          issue(ReqAdvance, $urandom_range(86400, 131071), $urandom, $urandom, $urandom);
      end
    end
    valid_i <= 1'b0;

    while (tracker.due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.faults == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ----- calendar_clock_advance.f -----
+incdir+rtl/core
rtl/core/cca_pkg.sv
rtl/core/cca_step.sv
rtl/core/calendar_clock_advance.sv
tb/calendar_clock_advance_tb.sv
